@@ src/grt_pkg.sv @@
`default_nettype none
package grt_pkg;

	// fixed field widths
	localparam int SCALE_W      = 3;
	localparam int STRIDE_W     = 13;
	localparam int FADDR_W      = 11;
	localparam int CODE_W       = 8;
	localparam int POSX_W       = 12;
	localparam int POSY_W       = 11;
	localparam int PADDR_W      = 24;
	localparam int MASK_W       = 24;
	localparam int RUN_W        = 5;
	localparam int IDX_W        = 8;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;

	// font geometry
	localparam int FONT_ROWS    = 8;
	localparam int FROW_W       = 3;
	localparam int GLYPH_WIDTH  = 6;
	localparam int GLYPHS_DEF   = 256;
	localparam int MAX_SCALE_DEF = 4;

	// command queue between front and back
	localparam int QDEPTH       = 4;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SCALE      = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE = 1'd1;

	// register reset values
	localparam logic [SCALE_W-1:0]  SCALE_RST      = 3'd1;
	localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 13'd640;

	// op codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	typedef struct packed {
		logic                op;
		logic [FADDR_W-1:0]  font_address;
		logic [7:0]          font_byte;
		logic [CODE_W-1:0]   char_code;
		logic [POSX_W-1:0]   pos_x;
		logic [POSY_W-1:0]   pos_y;
		logic                first;
	} grt_in_t;

	typedef struct packed {
		logic [PADDR_W-1:0]  pixel_address;
		logic [MASK_W-1:0]   dot_mask;
		logic [RUN_W-1:0]    run_length;
		logic                last;
	} grt_out_t;

	// one queued command: a font write or a classified character
	typedef struct packed {
		logic                is_load;
		logic [FADDR_W-1:0]  font_address;
		logic [7:0]          font_byte;
		logic [CODE_W-1:0]   glyph;
		logic [PADDR_W-1:0]  base;
		logic [SCALE_W-1:0]  scale;
		logic [RUN_W-1:0]    run_len;
	} grt_cmd_t;

	// repeat each of the six font dots s times; font bit 7 lands at bit 0
	function automatic logic [MASK_W-1:0] widen_row(input logic [7:0] bits,
		input logic [SCALE_W-1:0] s);
		logic [MASK_W-1:0] mask;
		int pos;
		mask = '0;
		for (int lx = 0; lx < GLYPH_WIDTH; lx++) begin
			for (int k = 0; k < 4; k++) begin
				pos = lx * int'(s) + k;
				if (bits[7-lx] && (k < int'(s)) && (pos < MASK_W))
					mask[pos] = 1'b1;
			end
		end
		return mask;
	endfunction

endpackage
`default_nettype wire

@@ src/grt_fifo.sv @@
`default_nettype none
module grt_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire grt_pkg::grt_cmd_t  wr_data,
	output logic                    full,
	input  wire logic               rd,
	output grt_pkg::grt_cmd_t       rd_data,
	output logic                    empty
);
	import grt_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	grt_cmd_t          mem_q [QDEPTH];
	logic [PW:0]       wptr_q;
	logic [PW:0]       rptr_q;

	assign empty   = (wptr_q == rptr_q);
	assign full    = (wptr_q[PW-1:0] == rptr_q[PW-1:0]) && (wptr_q[PW] != rptr_q[PW]);
	assign rd_data = mem_q[rptr_q[PW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
		end else begin
			if (wr && !full)
				wptr_q <= wptr_q + 1'b1;
			if (rd && !empty)
				rptr_q <= rptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr && !full)
			mem_q[wptr_q[PW-1:0]] <= wr_data;
	end

endmodule
`default_nettype wire

@@ src/grt_front.sv @@
`default_nettype none
module grt_front #(
	parameter int GLYPHS    = grt_pkg::GLYPHS_DEF,
	parameter int MAX_SCALE = grt_pkg::MAX_SCALE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	input  wire grt_pkg::grt_in_t             in_item,
	output logic                              full,
	input  wire logic [grt_pkg::SCALE_W-1:0]  scale,
	input  wire logic [grt_pkg::STRIDE_W-1:0] row_stride,
	output logic                              q_wr,
	output grt_pkg::grt_cmd_t                 q_data,
	input  wire logic                         q_full
);
	import grt_pkg::*;

	localparam int STORE = GLYPHS * FONT_ROWS;

	logic [CODE_W-1:0]          glyph_lut [256];
	logic [IDX_W-1:0]           char_index_q;
	logic [IDX_W-1:0]           idx;
	logic [SCALE_W-1:0]         eff_scale;
	logic [RUN_W-1:0]           run_len;
	logic                       accept;
	logic                       keep;
	logic                       adv;

	logic                       valid_s1;
	logic                       is_load_s1;
	logic [FADDR_W-1:0]         faddr_s1;
	logic [7:0]                 fbyte_s1;
	logic [CODE_W-1:0]          glyph_s1;
	logic [PADDR_W-1:0]         row_off_s1;
	logic [POSX_W-1:0]          px_s1;
	logic [IDX_W+RUN_W-1:0]     col_off_s1;
	logic [SCALE_W-1:0]         scale_s1;
	logic [RUN_W-1:0]           run_s1;

	// char_code modulo GLYPHS as a constant table
	for (genvar g = 0; g < 256; g++) begin : g_lut
		assign glyph_lut[g] = CODE_W'(g % GLYPHS);
	end

	always_comb begin
		if (scale == '0)
			eff_scale = SCALE_W'(1);
		else if (scale > SCALE_W'(MAX_SCALE))
			eff_scale = SCALE_W'(MAX_SCALE);
		else
			eff_scale = scale;
	end

	assign run_len = RUN_W'(GLYPH_WIDTH * eff_scale);
	assign idx     = in_item.first ? '0 : char_index_q;
	assign adv     = !valid_s1 || !q_full;
	assign full    = !adv;
	assign accept  = push && adv;
	// loads past the store are dropped here; they produce nothing
	assign keep    = (in_item.op == OP_RENDER) ||
	                 ({1'b0, in_item.font_address} < (FADDR_W+1)'(STORE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			char_index_q <= '0;
		end else begin
			if (adv)
				valid_s1 <= accept && keep;
			if (accept && in_item.op == OP_RENDER)
				char_index_q <= (idx == '1) ? idx : idx + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_load_s1 <= (in_item.op == OP_LOAD);
			faddr_s1   <= in_item.font_address;
			fbyte_s1   <= in_item.font_byte;
			glyph_s1   <= glyph_lut[in_item.char_code];
			row_off_s1 <= PADDR_W'(in_item.pos_y * row_stride);
			px_s1      <= in_item.pos_x;
			col_off_s1 <= (IDX_W+RUN_W)'(idx * run_len);
			scale_s1   <= eff_scale;
			run_s1     <= run_len;
		end
	end

	assign q_wr                = valid_s1;
	assign q_data.is_load      = is_load_s1;
	assign q_data.font_address = faddr_s1;
	assign q_data.font_byte    = fbyte_s1;
	assign q_data.glyph        = glyph_s1;
	assign q_data.base         = row_off_s1 + PADDR_W'(px_s1) + PADDR_W'(col_off_s1);
	assign q_data.scale        = scale_s1;
	assign q_data.run_len      = run_s1;

endmodule
`default_nettype wire

@@ src/grt_back.sv @@
`default_nettype none
module grt_back #(
	parameter int GLYPHS    = grt_pkg::GLYPHS_DEF,
	parameter int MAX_SCALE = grt_pkg::MAX_SCALE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire grt_pkg::grt_cmd_t            q_data,
	input  wire logic                         q_empty,
	output logic                              q_rd,
	input  wire logic [grt_pkg::STRIDE_W-1:0] row_stride,
	output grt_pkg::grt_out_t                 out_item,
	output logic                              empty,
	input  wire logic                         pop
);
	import grt_pkg::*;

	localparam int STORE = GLYPHS * FONT_ROWS;
	localparam int AW    = $clog2(STORE);
	localparam int SW    = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

	logic [7:0]           font_mem [STORE];

	logic                 act_q;
	logic [CODE_W-1:0]    glyph_q;
	logic [PADDR_W-1:0]   addr_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [RUN_W-1:0]     run_q;
	logic [FROW_W-1:0]    frow_q;
	logic [SW-1:0]        sub_q;

	logic                 out_valid_q;
	logic [7:0]           rd_q;
	logic [PADDR_W-1:0]   out_addr_q;
	logic [SCALE_W-1:0]   out_scale_q;
	logic [RUN_W-1:0]     out_run_q;
	logic                 out_last_q;

	logic                 take;
	logic                 adv;
	logic                 issue;
	logic                 sub_end;
	logic                 last_row;
	logic [AW-1:0]        raddr;

	assign take     = !act_q && !q_empty;
	assign q_rd     = take;
	assign adv      = !out_valid_q || pop;
	assign issue    = act_q && adv;
	assign sub_end  = (SCALE_W'(sub_q) == scale_q - 1'b1);
	assign last_row = sub_end && (frow_q == FROW_W'(FONT_ROWS - 1));
	assign raddr    = AW'({glyph_q, frow_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take && !q_data.is_load)
				act_q <= 1'b1;
			else if (issue && last_row)
				act_q <= 1'b0;
			if (adv)
				out_valid_q <= issue;
		end
	end

	// row walk: scale sub-rows per font row, address steps one line each
	always_ff @(posedge clk) begin
		if (take) begin
			glyph_q <= q_data.glyph;
			addr_q  <= q_data.base;
			scale_q <= q_data.scale;
			run_q   <= q_data.run_len;
			frow_q  <= '0;
			sub_q   <= '0;
		end else if (issue) begin
			addr_q <= addr_q + PADDR_W'(row_stride);
			if (sub_end) begin
				sub_q  <= '0;
				frow_q <= frow_q + 1'b1;
			end else begin
				sub_q <= sub_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_q        <= font_mem[raddr];
			out_addr_q  <= addr_q;
			out_scale_q <= scale_q;
			out_run_q   <= run_q;
			out_last_q  <= last_row;
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_data.is_load)
			font_mem[AW'(q_data.font_address)] <= q_data.font_byte;
	end

	assign empty                  = !out_valid_q;
	assign out_item.pixel_address = out_addr_q;
	assign out_item.dot_mask      = widen_row(rd_q, out_scale_q);
	assign out_item.run_length    = out_run_q;
	assign out_item.last          = out_last_q;

endmodule
`default_nettype wire

@@ src/glyph_text_rasterizer_unit.sv @@
// channel  | beat                          | handshake
// ---------+-------------------------------+------------------------------
// input    | in_item (grt_in_t)            | push / full, taken on push & !full
// result   | out_item (grt_out_t)          | empty / pop, taken on pop & !empty
// config   | cfg_index, cfg_data           | cfg_write, no wait
//
// A render beat yields 8*scale row beats, one per cycle while pop is held;
// the back end first picks the character off the queue. A font load is
// written into the font store when the back end takes it off the queue.
// The front end registers each beat's multiplies, then queues it.
// Reset (arst_n low) empties both ends and the queue, clears the string
// index, sets scale to 1 and row_stride to 640; font contents stay unknown.
// full rises only when the queue and the front stage are both occupied.
`default_nettype none
module glyph_text_rasterizer_unit #(
	parameter int GLYPHS    = grt_pkg::GLYPHS_DEF,
	parameter int MAX_SCALE = grt_pkg::MAX_SCALE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            push,
	input  wire grt_pkg::grt_in_t                in_item,
	output logic                                 full,
	output grt_pkg::grt_out_t                    out_item,
	output logic                                 empty,
	input  wire logic                            pop,
	input  wire logic                            cfg_write,
	input  wire logic [grt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [grt_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import grt_pkg::*;

	logic [SCALE_W-1:0]  scale_q;
	logic [STRIDE_W-1:0] row_stride_q;

	logic                q_wr;
	logic                q_full;
	logic                q_rd;
	logic                q_empty;
	grt_cmd_t            q_in;
	grt_cmd_t            q_out;

	// config registers; the user must see that they are written only while the unit is idle, the block has no check for it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= SCALE_RST;
			row_stride_q <= ROW_STRIDE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_SCALE:      scale_q      <= cfg_data[SCALE_W-1:0];
				REG_ROW_STRIDE: row_stride_q <= cfg_data[STRIDE_W-1:0];
				default:        ;
			endcase
		end
	end

	// front: clamp scale, string index, address products
	grt_front #(
		.GLYPHS    (GLYPHS),
		.MAX_SCALE (MAX_SCALE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.in_item    (in_item),
		.full       (full),
		.scale      (scale_q),
		.row_stride (row_stride_q),
		.q_wr       (q_wr),
		.q_data     (q_in),
		.q_full     (q_full)
	);

	// short command queue decouples the two halves
	grt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_in),
		.full    (q_full),
		.rd      (q_rd),
		.rd_data (q_out),
		.empty   (q_empty)
	);

	// back: font store and row walker; the font read register is the result stage
	grt_back #(
		.GLYPHS    (GLYPHS),
		.MAX_SCALE (MAX_SCALE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_data     (q_out),
		.q_empty    (q_empty),
		.q_rd       (q_rd),
		.row_stride (row_stride_q),
		.out_item   (out_item),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
module testbench;
	import grt_pkg::*;

	// quiet cycles tolerated before the run is declared hung; the long
	// receiver hold-off below is the biggest legal gap
	localparam int unsigned HANG_LIMIT   = 3000;
	// cycles to let font writes still queued inside the block retire
	localparam int unsigned SETTLE       = 24;
	localparam int unsigned HOLD_OFF     = 400;
	localparam int unsigned RANDOM_ITEMS = 40;
	localparam int unsigned SAT_CHARS    = 257;

	logic                   clk;
	logic                   arst_n;
	logic                   push;
	grt_in_t                in_item;
	logic                   full;
	grt_out_t               out_item;
	logic                   empty;
	logic                   pop;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	glyph_text_rasterizer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.in_item   (in_item),
		.full      (full),
		.out_item  (out_item),
		.empty     (empty),
		.pop       (pop),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ---------------------------------------------------------------
	// shadow state of the rasterizer
	// ---------------------------------------------------------------
	logic [7:0]          font_mem [0:GLYPHS_DEF*FONT_ROWS-1];
	bit                  font_written [0:GLYPHS_DEF*FONT_ROWS-1];
	logic [7:0]          string_index;
	logic [SCALE_W-1:0]  cur_scale;
	logic [STRIDE_W-1:0] cur_stride;

	// row beats still owed by the block, oldest first
	grt_out_t            expected_rows [$];
	// glyph codes whose eight rows are all written; only these get rendered
	int unsigned         ready_codes [$];

	int unsigned         fail_count;
	int unsigned         idle_cycles;
	bit                  no_idle;      // both sides run back to back while set
	int unsigned         hold_cycles;  // one-shot stall request for the row sink

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------
	function automatic int unsigned eff_scale();
		if (cur_scale == '0)
			return 1;
		if (cur_scale > MAX_SCALE_DEF)
			return MAX_SCALE_DEF;
		return cur_scale;
	endfunction

	// output bit b shows font dot b/s; dot 0 sits in font bit 7
	function automatic logic [MASK_W-1:0] stretch_dots(input logic [7:0] bits,
		input int unsigned s);
		logic [MASK_W-1:0] m;
		m = '0;
		for (int unsigned b = 0; b < GLYPH_WIDTH * s; b++)
			m[b] = bits[7 - b / s];
		return m;
	endfunction

	// apply one accepted beat to the shadow state and queue the rows it owes
	task automatic predict_beat(input grt_in_t item);
		int unsigned s;
		int unsigned idx;
		int unsigned col;
		int unsigned addr;
		int unsigned glyph_base;
		bit          complete;
		grt_out_t    row;
		if (item.op == OP_LOAD) begin
			// store spans the full 11-bit range, so every load lands
			font_mem[item.font_address] = item.font_byte;
			font_written[item.font_address] = 1'b1;
			glyph_base = {item.font_address[FADDR_W-1:FROW_W], 3'd0};
			complete = 1'b1;
			for (int r = 0; r < FONT_ROWS; r++)
				complete &= font_written[glyph_base + r];
			if (complete && !(item.font_address[FADDR_W-1:FROW_W] inside {ready_codes}))
				ready_codes.push_back(item.font_address[FADDR_W-1:FROW_W]);
			return;
		end
		s = eff_scale();
		idx = item.first ? 0 : string_index;
		string_index = IDX_W'((idx < 255) ? idx + 1 : 255);
		col = item.pos_x + idx * GLYPH_WIDTH * s;
		for (int unsigned r = 0; r < FONT_ROWS * s; r++) begin
			addr = (item.pos_y + r) * cur_stride + col;
			row.pixel_address = addr[PADDR_W-1:0];
			row.dot_mask = stretch_dots(font_mem[item.char_code * FONT_ROWS + r / s], s);
			row.run_length = RUN_W'(GLYPH_WIDTH * s);
			row.last = (r == FONT_ROWS * s - 1);
			expected_rows.push_back(row);
		end
	endtask

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------
	function automatic int unsigned draw_gap();
		return no_idle ? 0 : $urandom_range(0, 17);
	endfunction

	// every field random so that unused fields toggle too
	function automatic grt_in_t random_item();
		grt_in_t it;
		it.op           = 1'($urandom_range(0, 1));
		it.font_address = FADDR_W'($urandom_range(0, 2047));
		it.font_byte    = 8'($urandom_range(0, 255));
		it.char_code    = CODE_W'($urandom_range(0, 255));
		it.pos_x        = POSX_W'($urandom_range(0, 4095));
		it.pos_y        = POSY_W'($urandom_range(0, 2047));
		it.first        = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// push stays high across back-to-back beats; lowered only for a real gap
	task automatic send_item(input grt_in_t item);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= item;
		do @(posedge clk); while (full);
		predict_beat(item);
	endtask

	task automatic load_row(input int unsigned addr, input int unsigned bits);
		grt_in_t it;
		it = random_item();
		it.op = OP_LOAD;
		it.font_address = FADDR_W'(addr);
		it.font_byte = 8'(bits);
		send_item(it);
	endtask

	task automatic load_glyph(input int unsigned code);
		for (int r = 0; r < FONT_ROWS; r++)
			load_row(code * FONT_ROWS + r, $urandom_range(0, 255));
	endtask

	task automatic render(input int unsigned code, input int unsigned px,
		input int unsigned py, input bit starts_string);
		grt_in_t it;
		it = random_item();
		it.op = OP_RENDER;
		it.char_code = CODE_W'(code);
		it.pos_x = POSX_W'(px);
		it.pos_y = POSY_W'(py);
		it.first = starts_string;
		send_item(it);
	endtask

	function automatic int unsigned pick_ready();
		return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
	endfunction

	// drop push, let every owed row come out, then let queued font writes retire
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// only called with the block idle; the task waits again after lowering cfg_write
	// so back-to-back writes never assign cfg_write twice in one step
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		if (idx == REG_SCALE)
			cur_scale = data[SCALE_W-1:0];
		else
			cur_stride = data[STRIDE_W-1:0];
	endtask

	// ---------------------------------------------------------------
	// result side: pops with random stalls and checks every row beat
	// ---------------------------------------------------------------
	task automatic check_row(input grt_out_t got);
		grt_out_t want;
		if (expected_rows.size() == 0) begin
			$error("row beat with nothing pending: %h", got);
			fail_count++;
			return;
		end
		want = expected_rows.pop_front();
		if (got.pixel_address !== want.pixel_address) begin
			$error("pixel_address expected %0h got %0h", want.pixel_address,
				got.pixel_address);
			fail_count++;
		end
		if (got.dot_mask !== want.dot_mask) begin
			$error("dot_mask expected %06h got %06h", want.dot_mask, got.dot_mask);
			fail_count++;
		end
		if (got.run_length !== want.run_length) begin
			$error("run_length expected %0d got %0d", want.run_length, got.run_length);
			fail_count++;
		end
		if (got.last !== want.last) begin
			$error("last expected %0b got %0b", want.last, got.last);
			fail_count++;
		end
	endtask

	initial begin : row_sink
		int unsigned gap;
		pop <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			// a pending hold-off request replaces the normal random stall
			if (hold_cycles != 0) begin
				gap = hold_cycles;
				hold_cycles = 0;
			end else begin
				gap = draw_gap();
			end
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			check_row(out_item);
		end
	end

	// hang detector: any quiet stretch longer than the limit ends the run
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("[glyph_text_rasterizer_unit] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// reset register values; glyphs 0 and 255 with edge patterns, codes and
	// origin at their extremes, and a font write that lands between renders
	task automatic test_font_extremes();
		logic [7:0] pattern [0:7];
		pattern = '{8'h00, 8'hFF, 8'h80, 8'h04, 8'hA5, 8'h5A, 8'hFC, 8'h01};
		for (int r = 0; r < FONT_ROWS; r++)
			load_row(r, pattern[r]);
		for (int r = 0; r < FONT_ROWS; r++)
			load_row((GLYPHS_DEF - 1) * FONT_ROWS + r, 8'(~pattern[r]));
		render(0, 0, 0, 1'b1);
		render(GLYPHS_DEF - 1, 4095, 2047, 1'b0);
		// overwrite row 0 of glyph 0; the next render must see the new bits
		load_row(0, 8'hFF);
		render(0, 0, 0, 1'b1);
		render(GLYPHS_DEF - 1, 0, 2047, 1'b1);
		render(0, 4095, 0, 1'b0);
		wait_drained();
	endtask

	// scale codes 0 to 5 and 7, 0 and above the maximum included, against zero,
	// unit, largest and typical strides; far corner origins force the
	// address past 2^24
	task automatic test_scale_settings();
		logic [SCALE_W-1:0]  scales  [0:6];
		logic [STRIDE_W-1:0] strides [0:6];
		scales  = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7};
		strides = '{13'd0, 13'd1, 13'h1FFF, 13'd4096, 13'd640, 13'h1FFF, 13'd4097};
		for (int i = 0; i < 7; i++) begin
			write_reg(REG_SCALE, CFG_DATA_W'(scales[i]));
			write_reg(REG_ROW_STRIDE, strides[i]);
			render(0, 4095, 2047, 1'b1);
			render(GLYPHS_DEF - 1, 4095, 2047, 1'b0);
			wait_drained();
		end
	endtask

	// one long string so the character index climbs to 255 and sticks,
	// then a fresh string start pulls it back to zero
	task automatic test_index_saturation();
		write_reg(REG_SCALE, 13'd1);
		write_reg(REG_ROW_STRIDE, 13'd640);
		no_idle = 1'b1;
		for (int c = 0; c < SAT_CHARS; c++)
			render(pick_ready(), $urandom_range(0, 4095), $urandom_range(0, 2047), c == 0);
		render(pick_ready(), 0, 0, 1'b1);
		render(pick_ready(), 0, 0, 1'b0);
		no_idle = 1'b0;
		wait_drained();
	endtask

	// sink stalls for a long stretch while the source keeps offering
	// characters, so the block fills and raises full; the source then waits
	// for every owed row before going on
	task automatic test_backpressure();
		write_reg(REG_SCALE, 13'd4);
		hold_cycles = HOLD_OFF;
		no_idle = 1'b1;
		for (int c = 0; c < 12; c++)
			render(pick_ready(), $urandom_range(0, 4095), $urandom_range(0, 2047), c == 0);
		no_idle = 1'b0;
		wait_drained();
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_stride();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 13'h1FFF;
			2: return CFG_DATA_W'($urandom_range(4097, 8191));
			default: return CFG_DATA_W'($urandom_range(1, 4096));
		endcase
	endfunction

	// mostly strings of ready glyphs, with glyph uploads and stray font writes
	// mixed in; some strings continue an old index
	task automatic test_random_traffic();
		int unsigned sent;
		int unsigned since_cfg;
		int unsigned len;
		int unsigned pick;
		int unsigned px;
		int unsigned py;
		sent = 0;
		since_cfg = 0;
		while (sent < RANDOM_ITEMS) begin
			if (since_cfg >= 16) begin
				wait_drained();
				write_reg(REG_SCALE, CFG_DATA_W'($urandom_range(0, 7)));
				write_reg(REG_ROW_STRIDE, pick_stride());
				since_cfg = 0;
			end
			no_idle = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 15 || ready_codes.size() < 4) begin
				load_glyph($urandom_range(0, GLYPHS_DEF - 1));
				len = FONT_ROWS;
			end else if (pick < 25) begin
				load_row($urandom_range(0, 2047), $urandom_range(0, 255));
				len = 1;
			end else begin
				len = $urandom_range(1, 8);
				px = $urandom_range(0, 4095);
				py = $urandom_range(0, 2047);
				for (int c = 0; c < len; c++)
					render(pick_ready(), px, py, (c == 0) && ($urandom_range(0, 9) != 0));
			end
			sent += len;
			since_cfg += len;
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		in_item <= '0;
		cfg_write <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		fail_count = 0;
		no_idle = 1'b0;
		hold_cycles = 0;
		string_index = '0;
		cur_scale = SCALE_RST;
		cur_stride = ROW_STRIDE_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_font_extremes();
		test_scale_settings();
		test_index_saturation();
		test_backpressure();
		test_random_traffic();

		wait_drained();
		if (fail_count == 0 && expected_rows.size() == 0)
			$display("[glyph_text_rasterizer_unit] OK");
		else
			$display("[glyph_text_rasterizer_unit] ERROR");
		$finish;
	end

endmodule
`default_nettype wire
